// ----- rtl/core/rror_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// RIP-relative operand rewriter package
// Shared constants, status codes and the queue entry type.
// ---------------------------------------------------------------------------
package rror_pkg;

   // Default configuration of the top level.
   localparam int MAX_INSN_BYTES_DEF = 15;
   localparam int QUEUE_DEPTH_DEF    = 4;

   // Byte counter width covers the largest legal instruction length.
   localparam int COUNT_W = 4;

   // Result status codes.
   typedef logic [1:0] status_type;
   localparam status_type ST_OK     = 2'd0;
   localparam status_type ST_NORIP  = 2'd1;
   localparam status_type ST_LENGTH = 2'd2;

   // Encoding constants.
   localparam logic [7:0] BYTE_REX_B  = 8'h41;
   localparam logic [3:0] REX_HI      = 4'h4;
   localparam logic [7:0] REX_B_MASK  = 8'h01;
   localparam logic [7:0] ESC_0F      = 8'h0f;
   localparam logic [7:0] ESC_38      = 8'h38;
   localparam logic [7:0] ESC_3A      = 8'h3a;
   localparam logic [1:0] MOD_RIP     = 2'b00;
   localparam logic [1:0] MOD_DISP32  = 2'b10;
   localparam logic [2:0] RM_RIP      = 3'd5;
   localparam logic [2:0] RM_R14      = 3'd6;
   localparam logic [2:0] RM_R15      = 3'd7;
   localparam logic [7:0] ERROR_BYTE  = 8'h00;

   // One queue entry: a result byte, optionally preceded by an inserted REX.
   typedef struct packed {
      logic       ins_rex;
      logic [7:0] out_byte;
      logic       out_last;
      status_type status;
   } entry_type;

endpackage
`default_nettype wire

// ----- rtl/core/rror_req_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Request channel interface
// Valid/ready channel carrying one original instruction byte per request.
// ---------------------------------------------------------------------------
interface rror_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] in_byte;
   logic       in_last;
   logic       use_r14;

   modport source (output valid, output in_byte, output in_last, output use_r14,
                   input ready);
   modport sink   (input valid, input in_byte, input in_last, input use_r14,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rror_rsp_if.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// Response channel interface
// Valid/ready channel carrying one rewritten byte and its status.
// ---------------------------------------------------------------------------
interface rror_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] out_byte;
   logic       out_last;
   logic [1:0] status;

   modport source (output valid, output out_byte, output out_last, output status,
                   input ready);
   modport sink   (input valid, input out_byte, input out_last, input status,
                   output ready);
endinterface
`default_nettype wire

// ----- rtl/core/rror_front.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// RIP-relative rewriter front end
// Accepts instruction bytes, tracks the decode phase and builds queue entries.
// ---------------------------------------------------------------------------
module rror_front #(
   parameter int MAX_INSN_BYTES = rror_pkg::MAX_INSN_BYTES_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   rror_req_if.sink             req_chan,
   input  wire                  q_full,
   output logic                 push,
   output rror_pkg::entry_type  push_entry
);

   // Decode phase codes.
   localparam logic [2:0] PH_PREFIX = 3'd0;
   localparam logic [2:0] PH_OPC1   = 3'd1;
   localparam logic [2:0] PH_ESC    = 3'd2;
   localparam logic [2:0] PH_MAIN   = 3'd3;
   localparam logic [2:0] PH_MODRM  = 3'd4;
   localparam logic [2:0] PH_TAIL   = 3'd5;

   logic [2:0]                  phase_ff, phase_in;
   logic                        drop_ff, drop_in;
   logic [rror_pkg::COUNT_W-1:0] count_ff, count_in;
   logic                        accept;
   logic                        do_fail;
   logic                        do_start;
   rror_pkg::status_type        fail_st;

   // A request is taken whenever the queue has room.
   assign req_chan.ready = !q_full;
   assign accept         = req_chan.valid && req_chan.ready;

   // Phase machine and entry construction.
   always_comb begin
      phase_in   = phase_ff;
      drop_in    = drop_ff;
      count_in   = count_ff;
      push       = 1'b0;
      do_fail    = 1'b0;
      do_start   = 1'b0;
      fail_st    = rror_pkg::ST_OK;
      push_entry = '{ins_rex: 1'b0, out_byte: req_chan.in_byte, out_last: 1'b0,
                     status: rror_pkg::ST_OK};

      if (accept) begin
         if (drop_ff) begin
            // Skip the rest of a failed instruction.
            do_start = req_chan.in_last;
         end else if (count_ff >= rror_pkg::COUNT_W'(MAX_INSN_BYTES)) begin
            do_fail = 1'b1;
            fail_st = rror_pkg::ST_LENGTH;
         end else begin
            count_in = count_ff + 1'b1;
            if (req_chan.in_last && (phase_ff < PH_MODRM)) begin
               do_fail = 1'b1;
               fail_st = rror_pkg::ST_LENGTH;
            end else begin
               case (phase_ff)
                  PH_PREFIX: begin
                     push = 1'b1;
                     if (req_chan.in_byte inside {8'hf0, 8'hf2, 8'hf3, 8'h2e, 8'h36,
                                                  8'h3e, 8'h26, 8'h64, 8'h65,
                                                  8'h66, 8'h67}) begin
                        phase_in = PH_PREFIX;
                     end else if (req_chan.in_byte[7:4] == rror_pkg::REX_HI) begin
                        push_entry.out_byte = req_chan.in_byte | rror_pkg::REX_B_MASK;
                        phase_in = PH_OPC1;
                     end else begin
                        // No REX present: insert one ahead of the opcode.
                        push_entry.ins_rex = 1'b1;
                        phase_in = (req_chan.in_byte == rror_pkg::ESC_0F) ? PH_ESC
                                                                          : PH_MODRM;
                     end
                  end
                  PH_OPC1: begin
                     push     = 1'b1;
                     phase_in = (req_chan.in_byte == rror_pkg::ESC_0F) ? PH_ESC
                                                                       : PH_MODRM;
                  end
                  PH_ESC: begin
                     push     = 1'b1;
                     phase_in = ((req_chan.in_byte == rror_pkg::ESC_38) ||
                                 (req_chan.in_byte == rror_pkg::ESC_3A)) ? PH_MAIN
                                                                         : PH_MODRM;
                  end
                  PH_MAIN: begin
                     push     = 1'b1;
                     phase_in = PH_MODRM;
                  end
                  PH_MODRM: begin
                     if ((req_chan.in_byte[7:6] != rror_pkg::MOD_RIP) ||
                         (req_chan.in_byte[2:0] != rror_pkg::RM_RIP)) begin
                        do_fail = 1'b1;
                        fail_st = rror_pkg::ST_NORIP;
                     end else begin
                        push = 1'b1;
                        push_entry.out_byte = {rror_pkg::MOD_DISP32, req_chan.in_byte[5:3],
                                               req_chan.use_r14 ? rror_pkg::RM_R14
                                                                : rror_pkg::RM_R15};
                        push_entry.out_last = req_chan.in_last;
                        do_start = req_chan.in_last;
                        phase_in = PH_TAIL;
                     end
                  end
                  default: begin
                     push = 1'b1;
                     push_entry.out_last = req_chan.in_last;
                     do_start = req_chan.in_last;
                     phase_in = PH_TAIL;
                  end
               endcase
            end
         end

         // An error replaces the byte and ends the instruction's output.
         if (do_fail) begin
            push       = 1'b1;
            push_entry = '{ins_rex: 1'b0, out_byte: rror_pkg::ERROR_BYTE,
                           out_last: 1'b1, status: fail_st};
            if (req_chan.in_last) begin
               do_start = 1'b1;
            end else begin
               drop_in = 1'b1;
            end
         end

         if (do_start) begin
            phase_in = PH_PREFIX;
            drop_in  = 1'b0;
            count_in = '0;
         end
      end
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_PREFIX;
         drop_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         drop_ff  <= drop_in;
         count_ff <= count_in;
      end
   end

   // A new entry is only produced for an accepted request.
   assert property (@(posedge clock) disable iff (reset) push |-> accept)
      else $error("front pushed without an accepted request");

   // While dropping, nothing is queued.
   assert property (@(posedge clock) disable iff (reset) (accept && drop_ff) |-> !push)
      else $error("front queued a byte of a dropped instruction");

endmodule
`default_nettype wire

// ----- rtl/core/rror_queue.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// RIP-relative rewriter entry queue
// Small FIFO that decouples the front end from the response side.
// ---------------------------------------------------------------------------
module rror_queue #(
   parameter int DEPTH = rror_pkg::QUEUE_DEPTH_DEF
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push,
   input  rror_pkg::entry_type  push_entry,
   input  wire                  pop,
   output logic                 full,
   output logic                 empty,
   output rror_pkg::entry_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   rror_pkg::entry_type mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]    count_ff, count_in;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);
   assign head  = mem_ff[rd_ptr_ff];

   // Pointer and occupancy updates.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage needs no reset.
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   assert property (@(posedge clock) disable iff (reset) count_ff <= CNT_W'(DEPTH))
      else $error("queue occupancy beyond depth");

   assert property (@(posedge clock) disable iff (reset) push |-> (!full || pop))
      else $error("push into a full queue");

   assert property (@(posedge clock) disable iff (reset) pop |-> !empty)
      else $error("pop from an empty queue");

endmodule
`default_nettype wire

// ----- rtl/core/rror_back.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// RIP-relative rewriter back end
// Drains queue entries onto the response channel, expanding REX inserts.
// ---------------------------------------------------------------------------
module rror_back (
   input  wire                  clock,
   input  wire                  reset,
   input  rror_pkg::entry_type  head,
   input  wire                  q_empty,
   output logic                 pop,
   rror_rsp_if.source           rsp_chan
);

   logic sub_ff, sub_in;
   logic rex_slot;
   logic rsp_accept;

   // The inserted REX goes out first, then the entry's own byte.
   assign rex_slot   = head.ins_rex && !sub_ff;
   assign rsp_accept = rsp_chan.valid && rsp_chan.ready;

   assign rsp_chan.valid    = !q_empty;
   assign rsp_chan.out_byte = rex_slot ? rror_pkg::BYTE_REX_B : head.out_byte;
   assign rsp_chan.out_last = rex_slot ? 1'b0 : head.out_last;
   assign rsp_chan.status   = rex_slot ? rror_pkg::ST_OK : head.status;

   assign pop = rsp_accept && !rex_slot;

   // Track whether the inserted REX of the head entry was already sent.
   always_comb begin
      sub_in = sub_ff;
      if (rsp_accept) begin
         sub_in = rex_slot;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff <= 1'b0;
      end else begin
         sub_ff <= sub_in;
      end
   end

   assert property (@(posedge clock) disable iff (reset) sub_ff |-> (rsp_chan.valid && head.ins_rex))
      else $error("second half of a REX insert without its entry");

endmodule
`default_nettype wire

// ----- rtl/core/rip_relative_operand_rewriter.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// RIP-relative operand rewriter
// Rewrites RIP-relative x86-64 instructions to r14/r15-based addressing.
// ---------------------------------------------------------------------------
//
//   Channel   Dir   Handshake     Payload
//   req_chan  in    valid/ready   in_byte[7:0], in_last, use_r14
//   rsp_chan  out   valid/ready   out_byte[7:0], out_last, status[1:0]
//
// One request is taken per cycle while the entry queue has room.
// A request that needs an inserted REX yields two responses.
// Each result is registered in the entry queue before it is offered as a response.
// Reset is synchronous and clears the decode phase and the queue pointers.
// A stalled response side fills the queue, after which ready drops.
// ---------------------------------------------------------------------------
module rip_relative_operand_rewriter #(
   parameter int MAX_INSN_BYTES = rror_pkg::MAX_INSN_BYTES_DEF,
   parameter int QUEUE_DEPTH    = rror_pkg::QUEUE_DEPTH_DEF
) (
   input  wire         clock,
   input  wire         reset,
   rror_req_if.sink    req_chan,
   rror_rsp_if.source  rsp_chan
);

   logic                push;
   logic                pop;
   logic                q_full;
   logic                q_empty;
   rror_pkg::entry_type push_entry;
   rror_pkg::entry_type head;

   // Front end: classify bytes and queue results.
   rror_front #(
      .MAX_INSN_BYTES (MAX_INSN_BYTES)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   // Queue between the two halves.
   rror_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .full       (q_full),
      .empty      (q_empty),
      .head       (head)
   );

   // Back end: drive responses.
   rror_back u_back (
      .clock    (clock),
      .reset    (reset),
      .head     (head),
      .q_empty  (q_empty),
      .pop      (pop),
      .rsp_chan (rsp_chan)
   );

endmodule
`default_nettype wire
